// File: hdl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, constants and a helper function of the text console glyph
// renderer: field widths, codes, the colour palette and glyph address wrap.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_ROWS     = 16;
  localparam int GLYPH_COUNT    = 256;
  localparam int GLYPH_MEM_SIZE = GLYPH_COUNT * GLYPH_ROWS;
  localparam int GLYPH_AW       = $clog2(GLYPH_MEM_SIZE);
  localparam int GLYPH_ROW_SHIFT = $clog2(GLYPH_ROWS);
  localparam int RESULT_CAP     = 16;
  localparam int ROW_LIMIT      = (GLYPH_ROWS < RESULT_CAP) ? GLYPH_ROWS : RESULT_CAP;
  localparam int ROW_W          = $clog2(ROW_LIMIT);

  localparam int CODE_W         = 8;
  localparam int CODE_COUNT     = 2 ** CODE_W;
  localparam int GADDR_W        = 12;
  localparam int CODE_SPAN_W    = $clog2(CODE_COUNT * GLYPH_ROWS);
  localparam int WRAP_IN_W      = (CODE_SPAN_W > GADDR_W) ? CODE_SPAN_W : GADDR_W;
  localparam int WRAP_ACC_W     = WRAP_IN_W + 1;
  localparam int WRAP_STEPS     = (2 ** WRAP_IN_W + GLYPH_MEM_SIZE - 1) / GLYPH_MEM_SIZE;

  localparam int CFG_W          = 13;
  localparam int BPP_W          = 6;
  localparam int COL_W          = 16;
  localparam int ROWF_W         = 12;
  localparam int RGB_W          = 24;
  localparam int ADDR_W         = 26;
  localparam int PIX_W          = 4;
  localparam int START_W        = 32;
  localparam int COLUMNS_W      = CFG_W - 3;
  localparam int PRODPOS_W      = ROWF_W + COLUMNS_W;
  localparam int CELLS_W        = COLUMNS_W + CFG_W;
  localparam int POS_W          = ((PRODPOS_W > CELLS_W) ? PRODPOS_W : CELLS_W) + 2;
  localparam int ROWPIX_W       = ROWF_W + GLYPH_ROW_SHIFT + 1;
  localparam int ROWBASE_W      = ROWPIX_W + CFG_W;

  localparam logic [PIX_W-1:0] PIX_FULL = PIX_W'(8);

  localparam logic [1:0] ACT_PUT  = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_SET  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BPP    = 2'd2;

  localparam logic [CODE_W-1:0] CH_BS      = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CH_LF      = 8'd10;
  localparam logic [CODE_W-1:0] CH_CR      = 8'd13;
  localparam logic [CODE_W-1:0] BLANK_CODE = 8'h20;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [BPP_W-1:0] RST_BPP    = 6'd32;

  localparam logic [RGB_W-1:0] PALETTE [16] = '{
    24'h000000, 24'h000080, 24'h008000, 24'h008080,
    24'h800000, 24'h800080, 24'hAA5000, 24'h808080,
    24'h404040, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  typedef struct packed {
    logic [1:0]              action;
    logic [CODE_W-1:0]       char_code;
    logic [7:0]              style;
    logic [GADDR_W-1:0]      glyph_address;
    logic [7:0]              glyph_byte;
    logic signed [COL_W-1:0] new_column;
    logic [ROWF_W-1:0]       new_row;
    logic                    view_only;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       byte_address;
    logic [7:0]              row_bits;
    logic [PIX_W-1:0]        pixels_valid;
    logic [RGB_W-1:0]        fg_rgb;
    logic [RGB_W-1:0]        bg_rgb;
    logic                    last;
    logic signed [COL_W-1:0] cursor_column;
    logic [ROWF_W-1:0]       cursor_row;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [GLYPH_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [GLYPH_AW-1:0] raddr;
  } glyph_req_t;

  // Reduces an address modulo the glyph memory size by repeated compare and subtract.
  function automatic logic [GLYPH_AW-1:0] glyph_wrap(input logic [WRAP_IN_W-1:0] value);
    logic [WRAP_ACC_W-1:0] acc;
    acc = {1'b0, value};
    for (int k = 0; k < WRAP_STEPS; k++) begin
      if (acc >= WRAP_ACC_W'(GLYPH_MEM_SIZE)) begin
        acc = acc - WRAP_ACC_W'(GLYPH_MEM_SIZE);
      end
    end
    return acc[GLYPH_AW-1:0];
  endfunction

endpackage

// File: hdl/text_console_glyph_renderer_core.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core
// Text console renderer: draws 8-pixel glyph rows from a loadable glyph
// memory at the cursor cell and moves the cursor.
// ----------------------------------------------------------------------------
//  Channel   Direction  Item
//  s_axis    in         command: put character, load glyph byte, set cursor
//  m_axis    out        one glyph row: address, bits, valid pixels, colours
//  cfg       in         register write: width, height, bits per pixel
//
// A load or set-cursor command completes when accepted. A put runs position
// arithmetic and then emits one row per cycle, up to sixteen, paced by the
// single read port of the glyph memory. Reset clears the cursor and loads
// 640 x 480 at 32 bits per pixel; the glyph memory is not cleared. A low
// m_axis_tready holds the current row and pauses the row walk.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core
  import tcgr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // char_code[7:0], style[15:8], glyph_address[27:16], glyph_byte[35:28],
  // new_column[51:36], new_row[63:52], view_only[64]
  input  logic [71:0]      s_axis_tdata,
  // action[1:0]
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // byte_address[25:0], row_bits[33:26], pixels_valid[37:34], fg_rgb[61:38],
  // bg_rgb[85:62], cursor_column[101:86], cursor_row[113:102]
  output logic [119:0]     m_axis_tdata,
  output logic             m_axis_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  in_item_t   item;
  result_t    row_next;
  result_t    row_out;
  glyph_req_t glyph_req;
  logic [7:0] glyph_rdata;
  logic       out_free;
  logic       out_load;

  assign item.action        = s_axis_tuser;
  assign item.char_code     = s_axis_tdata[7:0];
  assign item.style         = s_axis_tdata[15:8];
  assign item.glyph_address = s_axis_tdata[27:16];
  assign item.glyph_byte    = s_axis_tdata[35:28];
  assign item.new_column    = s_axis_tdata[51:36];
  assign item.new_row       = s_axis_tdata[63:52];
  assign item.view_only     = s_axis_tdata[64];

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_MEM_SIZE)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (glyph_req.we),
    .waddr (glyph_req.waddr),
    .wdata (glyph_req.wdata),
    .re    (glyph_req.re),
    .raddr (glyph_req.raddr),
    .rdata (glyph_rdata)
  );

  tcgr_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .item        (item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_free    (out_free),
    .out_load    (out_load),
    .out_row     (row_next),
    .glyph_req   (glyph_req),
    .glyph_rdata (glyph_rdata)
  );

  tcgr_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .din   (row_next),
    .free  (out_free),
    .valid (m_axis_tvalid),
    .ready (m_axis_tready),
    .dout  (row_out)
  );

  assign m_axis_tdata = {6'b000000, row_out.cursor_row, row_out.cursor_column,
                         row_out.bg_rgb, row_out.fg_rgb, row_out.pixels_valid,
                         row_out.row_bits, row_out.byte_address};
  assign m_axis_tlast = row_out.last;

endmodule

// File: hdl/tcgr_ram.sv
// ----------------------------------------------------------------------------
// tcgr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/tcgr_out_reg.sv
// ----------------------------------------------------------------------------
// tcgr_out_reg
// Output holding register for result rows; decouples the glyph walk from the
// downstream ready.
// ----------------------------------------------------------------------------
module tcgr_out_reg
  import tcgr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  output logic    free,
  output logic    valid,
  input  logic    ready,
  output result_t dout
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      dout <= din;
    end
  end

endmodule

// File: hdl/tcgr_engine.sv
// ----------------------------------------------------------------------------
// tcgr_engine
// Command sequencer of the renderer: configuration registers, cursor, cell
// position checks and the row walk: one glyph row per cycle unless stalled.
// ----------------------------------------------------------------------------
module tcgr_engine
  import tcgr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             out_free,
  output logic             out_load,
  output result_t          out_row,
  output glyph_req_t       glyph_req,
  input  logic [7:0]       glyph_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_POS, S_CHECK, S_BASE, S_START, S_ADDR, S_EMIT
  } state_t;

  state_t                    state;
  logic signed [COL_W-1:0]   cur_col;
  logic [ROWF_W-1:0]         cur_row;
  logic [CFG_W-1:0]          scr_w;
  logic [CFG_W-1:0]          scr_h;
  logic [BPP_W-1:0]          bpp;
  logic [CODE_W-1:0]         code;
  logic [7:0]                style;
  logic                      blank;
  logic [RGB_W-1:0]          fg;
  logic [RGB_W-1:0]          bg;
  logic [PRODPOS_W-1:0]      prod_pos;
  logic [CELLS_W-1:0]        cells;
  logic signed [COL_W-1:0]   draw_col;
  logic [ROWF_W-1:0]         draw_row;
  logic [ROWBASE_W-1:0]      rowbase;
  logic [ADDR_W-1:0]         size;
  logic [ADDR_W-1:0]         stride;
  logic signed [START_W-1:0] start;
  logic signed [START_W-1:0] start_next;
  logic [ADDR_W-1:0]         addr;
  logic [ROW_W-1:0]          row_idx;

  logic                      accept;
  logic [COLUMNS_W-1:0]      columns;
  logic [CFG_W-1:0]          rows;
  logic [2:0]                bytes;
  logic signed [POS_W-1:0]   pos;
  logic                      on_screen;
  logic                      ctrl;
  logic signed [COL_W-1:0]   mv_col;
  logic [ROWF_W-1:0]         mv_row;
  logic                      cur_ok;
  logic                      nxt_ok;
  logic [ADDR_W-1:0]         rem;
  logic [PIX_W-1:0]          pix;
  logic                      last_row;
  logic                      advance;
  logic [ROW_W-1:0]          rd_row;

  always_comb begin
    accept    = in_valid && (state == S_IDLE);
    in_ready  = (state == S_IDLE);
    cfg_ready = 1'b1;
    columns   = scr_w[CFG_W-1:3];
    rows      = scr_h >> GLYPH_ROW_SHIFT;
    bytes     = bpp[BPP_W-1:3];

    pos = $signed(POS_W'(prod_pos)) + POS_W'(cur_col);
    on_screen = pos < $signed(POS_W'(cells));

    ctrl   = (code == CH_BS) || (code == CH_TAB) || (code == CH_LF) || (code == CH_CR);
    mv_col = cur_col;
    mv_row = cur_row;
    case (code)
      CH_BS:   mv_col = cur_col - COL_W'(1);
      CH_TAB:  mv_col = cur_col + COL_W'(4);
      CH_LF:   mv_row = cur_row + ROWF_W'(1);
      CH_CR:   mv_col = '0;
      default: mv_col = cur_col + COL_W'(1);
    endcase

    cur_ok   = !start[START_W-1] && (start[START_W-2:0] < (START_W-1)'(size));
    nxt_ok   = !start_next[START_W-1] && (start_next[START_W-2:0] < (START_W-1)'(size));
    rem      = size - start[ADDR_W-1:0];
    pix      = (rem >= ADDR_W'(8)) ? PIX_FULL : rem[PIX_W-1:0];
    last_row = (pix != PIX_FULL) || (row_idx == ROW_W'(ROW_LIMIT - 1)) || !nxt_ok;

    out_load = (state == S_EMIT) && cur_ok && out_free;
    advance  = out_load && !last_row;

    out_row.byte_address  = addr;
    out_row.row_bits      = blank ? 8'h00 : glyph_rdata;
    out_row.pixels_valid  = pix;
    out_row.fg_rgb        = fg;
    out_row.bg_rgb        = bg;
    out_row.last          = last_row;
    out_row.cursor_column = cur_col;
    out_row.cursor_row    = cur_row;

    rd_row          = (state == S_ADDR) ? '0 : row_idx + ROW_W'(1);
    glyph_req.we    = accept && (item.action == ACT_LOAD);
    glyph_req.waddr = glyph_wrap(WRAP_IN_W'(item.glyph_address));
    glyph_req.wdata = item.glyph_byte;
    glyph_req.re    = (state == S_ADDR) || advance;
    glyph_req.raddr = glyph_wrap(WRAP_IN_W'(code) * WRAP_IN_W'(GLYPH_ROWS)
                                 + WRAP_IN_W'(rd_row));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur_col <= '0;
      cur_row <= '0;
      scr_w   <= RST_WIDTH;
      scr_h   <= RST_HEIGHT;
      bpp     <= RST_BPP;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WIDTH:  scr_w <= cfg_data;
          CFG_HEIGHT: scr_h <= cfg_data;
          CFG_BPP:    bpp   <= cfg_data[BPP_W-1:0];
          default:    ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.action)
              ACT_PUT: begin
                code  <= item.char_code;
                style <= item.style;
                state <= S_POS;
              end
              ACT_SET: begin
                if (!item.view_only) begin
                  cur_col <= item.new_column;
                  cur_row <= item.new_row;
                end
              end
              default: ;
            endcase
          end
        end
        S_POS: begin
          prod_pos <= PRODPOS_W'(cur_row) * PRODPOS_W'(columns);
          cells    <= CELLS_W'(columns) * CELLS_W'(rows);
          state    <= S_CHECK;
        end
        S_CHECK: begin
          if (pos < 0) begin
            state <= S_IDLE;
          end else begin
            cur_col <= mv_col;
            cur_row <= mv_row;
            if (ctrl) begin
              draw_col <= mv_col;
              draw_row <= mv_row;
              blank    <= 1'b1;
              fg       <= '0;
              bg       <= '0;
              code     <= BLANK_CODE;
            end else begin
              draw_col <= cur_col;
              draw_row <= cur_row;
              blank    <= 1'b0;
              fg       <= PALETTE[style[3:0]];
              bg       <= PALETTE[style[7:4]];
            end
            state <= on_screen ? S_BASE : S_IDLE;
          end
        end
        S_BASE: begin
          rowbase <= ROWBASE_W'(ROWPIX_W'(draw_row) * ROWPIX_W'(GLYPH_ROWS))
                     * ROWBASE_W'(scr_w);
          size    <= ADDR_W'(scr_w) * ADDR_W'(scr_h);
          stride  <= ADDR_W'(scr_w) * ADDR_W'(bytes);
          state   <= S_START;
        end
        S_START: begin
          start <= $signed(START_W'(rowbase))
                   + $signed({{(START_W-COL_W-3){draw_col[COL_W-1]}}, draw_col, 3'b000});
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr       <= ADDR_W'(start[ADDR_W-1:0] * ADDR_W'(bytes));
          start_next <= start + $signed(START_W'(scr_w));
          row_idx    <= '0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!cur_ok) begin
            state <= S_IDLE;
          end else if (out_free) begin
            if (last_row) begin
              state <= S_IDLE;
            end else begin
              row_idx    <= row_idx + ROW_W'(1);
              start      <= start_next;
              start_next <= start_next + $signed(START_W'(scr_w));
              addr       <= addr + stride;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/text_console_glyph_renderer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core_test
// Self-checking bench for the text console glyph renderer. Commands go in on
// the s_axis stream and a model of the console in this file (glyph memory,
// cursor and screen registers) predicts every glyph row the block must send.
// Each row on m_axis is compared field by field with the oldest prediction.
// The run loads glyphs, walks the cursor through its special positions, uses
// several screen settings including 8 x 16 and 4096 x 4096, and then sends
// random commands under changing stalls on both streams.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core_test;
  import tcgr_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CODE_W-1:0] CONTROL_CODES [4] = '{CH_BS, CH_TAB, CH_LF, CH_CR};
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [119:0]       m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  logic               hold_request = 1'b0;
  int                 hold_left = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  // Console state as the block should hold it.
  logic [7:0]              glyph_mem [GLYPH_MEM_SIZE];
  bit                      glyph_known [GLYPH_MEM_SIZE];
  bit                      code_listed [CODE_COUNT];
  logic [CODE_W-1:0]       ready_codes [$];
  logic signed [COL_W-1:0] cur_col = '0;
  logic [ROWF_W-1:0]       cur_row = '0;
  logic [CFG_W-1:0]        scr_width = RST_WIDTH;
  logic [CFG_W-1:0]        scr_height = RST_HEIGHT;
  logic [BPP_W-1:0]        scr_bpp = RST_BPP;

  result_t pending_rows [$];
  int      error_count = 0;
  int      commands_sent = 0;
  int      rows_checked = 0;
  int      screen_settings = 1;

  text_console_glyph_renderer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  // Updates the console state for one accepted command and queues the glyph
  // rows it must produce.
  task automatic render_command(input in_item_t cmd);
    longint            columns, cells, pos, w, area, start;
    logic [CODE_W-1:0] code, gcode;
    logic [RGB_W-1:0]  fg, bg;
    logic              blank;
    bit                complete, stop;
    int                valid;
    result_t           row;
    result_t           cell_rows [$];
    case (cmd.action)
      ACT_LOAD: begin
        glyph_mem[cmd.glyph_address] = cmd.glyph_byte;
        glyph_known[cmd.glyph_address] = 1'b1;
        gcode = cmd.glyph_address[GADDR_W-1:GLYPH_ROW_SHIFT];
        complete = 1'b1;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          complete &= glyph_known[int'(gcode) * GLYPH_ROWS + r];
        end
        if (complete && !code_listed[gcode]) begin
          code_listed[gcode] = 1'b1;
          ready_codes.push_back(gcode);
        end
      end
      ACT_SET: begin
        if (!cmd.view_only) begin
          cur_col = cmd.new_column;
          cur_row = cmd.new_row;
        end
      end
      ACT_PUT: begin
        columns = longint'(scr_width) / 8;
        cells = columns * (longint'(scr_height) / GLYPH_ROWS);
        pos = longint'(cur_row) * columns + longint'(cur_col);
        if (pos >= 0) begin
          blank = cmd.char_code inside {CH_BS, CH_TAB, CH_LF, CH_CR};
          code = cmd.char_code;
          fg = PALETTE[cmd.style[3:0]];
          bg = PALETTE[cmd.style[7:4]];
          if (blank) begin
            case (cmd.char_code)
              CH_BS:   cur_col = cur_col - 16'sd1;
              CH_TAB:  cur_col = cur_col + 16'sd4;
              CH_LF:   cur_row = cur_row + 12'd1;
              default: cur_col = '0;
            endcase
            code = BLANK_CODE;
            fg = '0;
            bg = '0;
          end
          if (pos < cells) begin
            w = longint'(scr_width);
            area = w * longint'(scr_height);
            stop = 1'b0;
            for (int i = 0; i < ROW_LIMIT && !stop; i++) begin
              start = longint'(cur_col) * 8 + (longint'(i) + longint'(cur_row) * GLYPH_ROWS) * w;
              valid = 0;
              while (valid < 8 && start + valid >= 0 && start + valid < area) begin
                valid++;
              end
              if (valid == 0) begin
                stop = 1'b1;
              end else begin
                row.byte_address = ADDR_W'(start * (longint'(scr_bpp) / 8));
                row.row_bits = blank ? 8'h00 :
                               glyph_mem[(int'(code) * GLYPH_ROWS + i) % GLYPH_MEM_SIZE];
                row.pixels_valid = PIX_W'(valid);
                row.fg_rgb = fg;
                row.bg_rgb = bg;
                row.last = 1'b0;
                cell_rows.push_back(row);
                stop = valid < 8;
              end
            end
          end
          if (!blank) begin
            cur_col = cur_col + 16'sd1;
          end
          for (int k = 0; k < cell_rows.size(); k++) begin
            row = cell_rows[k];
            row.last = (k == cell_rows.size() - 1);
            row.cursor_column = cur_col;
            row.cursor_row = cur_row;
            pending_rows.push_back(row);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic in_item_t random_item(input logic [1:0] action);
    in_item_t it;
    it.action = action;
    it.char_code = 8'($urandom);
    it.style = 8'($urandom);
    it.glyph_address = 12'($urandom);
    it.glyph_byte = 8'($urandom);
    it.new_column = 16'($urandom);
    it.new_row = 12'($urandom);
    it.view_only = 1'($urandom);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.action;
    s_axis_tdata <= {7'b0, it.view_only, it.new_row, it.new_column, it.glyph_byte,
                     it.glyph_address, it.style, it.char_code};
    do @(posedge clk); while (!s_axis_tready);
    render_command(it);
    commands_sent++;
  endtask

  task automatic put_char(input logic [CODE_W-1:0] code, input logic [7:0] style);
    in_item_t it;
    it = random_item(ACT_PUT);
    it.char_code = code;
    it.style = style;
    send_item(it);
  endtask

  task automatic set_cursor(input int col, input int row, input bit view);
    in_item_t it;
    it = random_item(ACT_SET);
    it.new_column = 16'(col);
    it.new_row = 12'(row);
    it.view_only = view;
    send_item(it);
  endtask

  task automatic load_glyph(input int addr, input logic [7:0] value);
    in_item_t it;
    it = random_item(ACT_LOAD);
    it.glyph_address = 12'(addr);
    it.glyph_byte = value;
    send_item(it);
  endtask

  task automatic put_ready_char();
    put_char(ready_codes[$urandom_range(ready_codes.size() - 1)], 8'($urandom));
  endtask

  task automatic wait_for_rows(input int limit);
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_rows.size() != 0) begin
      report_error($sformatf("%0d glyph rows never arrived", pending_rows.size()));
      pending_rows.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_screen(input int width, input int height, input int bpp);
    logic [1:0]       regs [3];
    logic [CFG_W-1:0] values [3];
    regs = '{CFG_WIDTH, CFG_HEIGHT, CFG_BPP};
    values = '{CFG_W'(width), CFG_W'(height), CFG_W'(bpp)};
    wait_for_rows(DRAIN_LIMIT);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= values[k];
      do @(posedge clk); while (!cfg_ready);
      case (regs[k])
        CFG_WIDTH:  scr_width = values[k];
        CFG_HEIGHT: scr_height = values[k];
        default:    scr_bpp = values[k][BPP_W-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
    screen_settings++;
  endtask

  task automatic test_glyph_loading();
    logic [CODE_W-1:0] codes [7];
    codes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h41, BLANK_CODE, 8'h7E};
    for (int k = 0; k < 7; k++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        load_glyph(int'(codes[k]) * GLYPH_ROWS + r,
                   (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom));
      end
    end
  endtask

  task automatic test_directed_commands();
    in_item_t it;
    set_cursor(0, 0, 1'b0);
    put_char(8'h41, 8'h0F);
    put_char(8'hFF, 8'hF0);
    put_char(8'h00, 8'h5A);
    put_char(8'h55, 8'h00);
    put_char(8'hAA, 8'hFF);
    put_char(CH_TAB, 8'h12);
    put_char(CH_LF, 8'h34);
    put_char(CH_CR, 8'h56);
    // Backspace from the first column of a lower line blanks column -1.
    put_char(CH_BS, 8'h78);
    set_cursor(0, 0, 1'b0);
    put_char(CH_BS, 8'h9A);
    // The cursor now sits at a negative position, so this put is dropped.
    put_char(8'h41, 8'hBC);
    set_cursor(100, 7, 1'b1);
    set_cursor(79, 29, 1'b0);
    put_char(8'h7E, 8'hC3);
    set_cursor(32767, 0, 1'b0);
    put_char(8'h41, 8'hDE);
    set_cursor(32765, 3, 1'b0);
    put_char(CH_TAB, 8'h21);
    set_cursor(5, 4095, 1'b0);
    put_char(CH_LF, 8'h43);
    it = random_item(ACT_UNUSED);
    send_item(it);
  endtask

  task automatic test_screen_edges();
    // A nine pixel wide screen lets the third glyph row run off the end.
    configure_screen(9, 33, 8);
    set_cursor(-2, 2, 1'b0);
    put_char(8'h55, 8'h1E);
    configure_screen(8, 16, 8);
    set_cursor(0, 0, 1'b0);
    put_char(8'h41, 8'h2D);
    put_char(8'hAA, 8'h3C);
    configure_screen(4096, 4096, 32);
    set_cursor(511, 255, 1'b0);
    put_char(8'hFF, 8'h4B);
    set_cursor(0, 255, 1'b0);
    put_char(CH_CR, 8'h00);
    configure_screen(640, 480, 16);
    set_cursor(40, 12, 1'b0);
    put_char(8'h00, 8'h69);
    configure_screen(640, 480, 24);
    put_char(8'h41, 8'h87);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input int max_width, input int max_height);
    int       pick, columns, rows, code;
    in_item_t it;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 35 == 0) begin
        configure_screen($urandom_range(8, max_width), $urandom_range(16, max_height),
                         ($urandom_range(3) == 0) ? $urandom_range(8, 32)
                                                  : 8 * $urandom_range(1, 4));
      end
      columns = int'(scr_width) / 8;
      rows = int'(scr_height) / GLYPH_ROWS;
      pick = $urandom_range(99);
      if (pick < 45) begin
        put_ready_char();
      end else if (pick < 60) begin
        put_char(CONTROL_CODES[$urandom_range(3)], 8'($urandom));
      end else if (pick < 80) begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          set_cursor($urandom_range(0, columns - 1), $urandom_range(0, rows - 1),
                     $urandom_range(4) == 0);
        end else if (pick < 8) begin
          set_cursor(-int'($urandom_range(0, 3 * columns + 8)), $urandom_range(0, rows + 4),
                     $urandom_range(4) == 0);
        end else begin
          set_cursor($urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(4) == 0);
        end
      end else if (pick < 92) begin
        load_glyph($urandom_range(0, GLYPH_MEM_SIZE - 1), 8'($urandom));
      end else if (pick < 95) begin
        code = $urandom_range(0, CODE_COUNT - 1);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          load_glyph(code * GLYPH_ROWS + r, 8'($urandom));
        end
      end else begin
        it = random_item(ACT_UNUSED);
        send_item(it);
      end
    end
  endtask

  task automatic test_output_backpressure();
    configure_screen(640, 480, 32);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_cursor(10, 3, 1'b0);
    s_axis_tvalid <= 1'b0;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    repeat (12) put_ready_char();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    m_axis_tready <= !hold_request && hold_left <= 1 &&
                     int'($urandom_range(99)) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.byte_address = m_axis_tdata[25:0];
      got.row_bits = m_axis_tdata[33:26];
      got.pixels_valid = m_axis_tdata[37:34];
      got.fg_rgb = m_axis_tdata[61:38];
      got.bg_rgb = m_axis_tdata[85:62];
      got.cursor_column = m_axis_tdata[101:86];
      got.cursor_row = m_axis_tdata[113:102];
      got.last = m_axis_tlast;
      if (pending_rows.size() == 0) begin
        report_error("glyph row received with no row pending");
      end else begin
        want = pending_rows.pop_front();
        check_field("byte_address", got.byte_address, want.byte_address);
        check_field("row_bits", got.row_bits, want.row_bits);
        check_field("pixels_valid", got.pixels_valid, want.pixels_valid);
        check_field("fg_rgb", got.fg_rgb, want.fg_rgb);
        check_field("bg_rgb", got.bg_rgb, want.bg_rgb);
        check_field("last", got.last, want.last);
        check_field("cursor_column", got.cursor_column, want.cursor_column);
        check_field("cursor_row", got.cursor_row, want.cursor_row);
        rows_checked++;
      end
    end
  end

  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 87;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_glyph_loading();
    test_directed_commands();
    test_screen_edges();
    test_random_traffic(60, 19, 87, 1024, 512);
    test_random_traffic(60, 87, 19, 64, 96);
    test_random_traffic(60, 0, 0, 4096, 4096);
    test_output_backpressure();
    wait_for_rows(DRAIN_LIMIT);
    $display("Sent %0d commands and compared %0d glyph rows over %0d screen settings,",
             commands_sent, rows_checked, screen_settings);
    $display("with glyph loads, cursor moves, control codes and stalls on both streams.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
hdl/tcgr_pkg.sv
hdl/tcgr_ram.sv
hdl/tcgr_out_reg.sv
hdl/tcgr_engine.sv
hdl/text_console_glyph_renderer_core.sv
tb/text_console_glyph_renderer_core_test.sv
